### hdl/isl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg: shared types for the indexed shift list
// Command and status codes, plus the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package isl_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_ctrl_t;

endpackage

### hdl/indexed_shift_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_list: bounded ordered list with insert/remove at index
// A row of cells shifts all entries in parallel, so every command finishes
// in the cycle it is accepted.
// ----------------------------------------------------------------------------
// Result: the result word is loaded into the output reg when the input is accepted.
// Throughput: one word per cycle while not stalled; every cell moves in the same edge.
// Input stalls only while a finished result is held by output stall.
// Reset clears the fill count and output valid; stored words stay undefined
// and are never read before they are written.
module indexed_shift_list
  import isl_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  position,
  input  logic [31:0] element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic [4:0]  count,
  output logic [1:0]  status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 4) ? CW : 4;
  localparam int MW = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int OW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] FullCount = CW'(CAPACITY);

  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_next;

  logic                                in_accept;
  cmd_t                                cmd;
  status_t                             st_calc;
  logic [IW-1:0]                       pos_ext;
  logic [IW-1:0]                       cnt_ext;
  logic [IW-1:0]                       at;
  logic                                is_add;
  logic                                full;
  cell_ctrl_t                          ctrl;
  logic [MW-1:0]                       elem_wide;
  logic [WORD_BITS-1:0]                elem_word;
  logic [CAPACITY-1:0][WORD_BITS-1:0]  words;
  logic [CAPACITY-1:0][WORD_BITS-1:0]  taps;
  logic [WORD_BITS-1:0]                tap_or;
  logic [MW-1:0]                       value_wide;
  logic [31:0]                         value_next;
  logic [OW-1:0]                       count_wide;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign cmd     = cmd_t'(command);
  assign pos_ext = IW'(position);
  assign cnt_ext = IW'(fill_count);
  assign is_add  = (cmd == CMD_APPEND) || (cmd == CMD_INSERT);
  assign full    = (fill_count == FullCount);
  assign at      = (cmd == CMD_APPEND) ? cnt_ext : pos_ext;

  always_comb begin
    if (is_add) begin
      // full is checked before the index
      if (full) begin
        st_calc = ST_FULL;
      end else if (at > cnt_ext) begin
        st_calc = ST_RANGE;
      end else begin
        st_calc = ST_DONE;
      end
    end else begin
      st_calc = (pos_ext >= cnt_ext) ? ST_RANGE : ST_DONE;
    end
  end

  always_comb begin
    ctrl.insert_en = in_accept && (st_calc == ST_DONE) && is_add;
    ctrl.remove_en = in_accept && (st_calc == ST_DONE) && (cmd == CMD_REMOVE);
  end

  always_comb begin
    fill_next = fill_count;
    if (ctrl.insert_en) begin
      fill_next = fill_count + CW'(1);
    end else if (ctrl.remove_en) begin
      fill_next = fill_count - CW'(1);
    end
  end

  assign elem_wide = MW'(element);
  assign elem_word = elem_wide[WORD_BITS-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    isl_cell #(
      .WORD_BITS (WORD_BITS),
      .IW        (IW),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .at         (at),
      .elem       (elem_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

  // at most one cell matches, so an OR picks its word
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  assign value_wide = MW'(tap_or);
  assign value_next = (!is_add && (st_calc == ST_DONE)) ? value_wide[31:0] : 32'd0;
  assign count_wide = OW'(fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      fill_count <= fill_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_value <= value_next;
      count      <= count_wide[4:0];
      status     <= st_calc;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FullCount)
    else $error("fill count above capacity");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    in_accept && (st_calc != ST_DONE) |=> fill_count == $past(fill_count))
    else $error("refused command changed the fill count");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> full)
    else $error("full status reported on a list that is not full");

  a_value_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_value != 32'd0) |-> status == ST_DONE)
    else $error("nonzero read value on a refused command");

endmodule

### hdl/isl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_cell: one slot of the shift list
// Holds a single word. On insert takes the left neighbor above the index and
// elem at it; on remove the right at or above it; offers its word on a match.
// ----------------------------------------------------------------------------
module isl_cell
  import isl_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int IW        = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [IW-1:0]        at,
  input  logic [WORD_BITS-1:0] elem,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  output logic [WORD_BITS-1:0] word,
  output logic [WORD_BITS-1:0] tap
);

  localparam logic [IW-1:0] MyIndex = IW'(INDEX);

  logic [WORD_BITS-1:0] word_next;
  logic                 hit;

  assign hit = (at == MyIndex);

  always_comb begin
    word_next = word;
    if (ctrl.insert_en) begin
      // shift up above the insert point, load the new word at it
      if (MyIndex > at) begin
        word_next = left_word;
      end else if (hit) begin
        word_next = elem;
      end
    end else if (ctrl.remove_en) begin
      // close the gap from the right
      if (MyIndex >= at) begin
        word_next = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign tap = hit ? word : '0;

endmodule
